/* rtl/core/poa_pkg.sv */
// Shared types and constants for the page ownership allocator.
`timescale 1ns / 1ps
`default_nettype none

package poa_pkg;

   localparam int PAGE_COUNT_DEF = 32;
   localparam int MAX_RESULTS    = 32;
   localparam int OWNER_W        = 8;
   localparam int COUNT_W        = 6;
   localparam int PAGE_NUM_W     = 5;

   localparam logic CMD_RECLAIM = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ALLOC,
      ST_RC_READ,
      ST_RC_EVAL,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      EMIT_PAGE,
      EMIT_FAIL,
      EMIT_ACK
   } emit_kind_type;

   typedef struct packed {
      logic          latch;
      logic          claim;
      logic          release_page;
      logic          step;
      logic          rd;
      logic          emit;
      emit_kind_type emit_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_reclaim;
      logic alloc_ok;
      logic page_free;
      logic owner_match;
      logic idx_at_end;
      logic last_claim;
      logic slot_free;
   } dp_stat_type;

endpackage

`default_nettype wire

/* rtl/core/poa_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module poa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/poa_ctrl.sv */
// Sequencer for allocate and reclaim scans.
`timescale 1ns / 1ps
`default_nettype none

module poa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire poa_pkg::dp_stat_type stat,
   output poa_pkg::ctrl_cmd_type     cmd
);
   import poa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.emit_kind = EMIT_PAGE;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_reclaim) begin
               state_in = ST_RC_READ;
            end else if (stat.alloc_ok) begin
               state_in = ST_ALLOC;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_ALLOC: begin
            if (!stat.page_free) begin
               cmd.step = 1'b1;
            end else if (stat.slot_free) begin
               cmd.claim = 1'b1;
               cmd.emit  = 1'b1;
               cmd.step  = 1'b1;
               if (stat.last_claim) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RC_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_RC_EVAL;
         end
         ST_RC_EVAL: begin
            cmd.release_page = stat.owner_match;
            if (stat.idx_at_end) begin
               state_in = ST_RESP;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RC_READ;
            end
         end
         ST_RESP: begin
            cmd.emit_kind = stat.is_reclaim ? EMIT_ACK : EMIT_FAIL;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/poa_datapath.sv */
// Page table, free count, scan index and result register.
`timescale 1ns / 1ps
`default_nettype none

module poa_datapath #(
   parameter int PAGE_COUNT = poa_pkg::PAGE_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire poa_pkg::ctrl_cmd_type              cmd,
   output poa_pkg::dp_stat_type                    stat,
   input  wire logic                               req_cmd,
   input  wire logic [poa_pkg::OWNER_W-1:0]        req_owner_id,
   input  wire logic [poa_pkg::COUNT_W-1:0]        req_page_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [poa_pkg::PAGE_NUM_W-1:0]     rsp_page_number,
   output logic                                    rsp_status,
   output logic                                    rsp_last
);
   import poa_pkg::*;

   localparam int IDX_W = $clog2(PAGE_COUNT);
   localparam int CNT_W = $clog2(PAGE_COUNT + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic                  cmd_ff;
   logic [OWNER_W-1:0]    id_ff;
   logic [COUNT_W-1:0]    want_ff;
   logic [COUNT_W-1:0]    claimed_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      free_cnt_ff;
   logic [PAGE_COUNT-1:0] used_ff;
   logic [OWNER_W-1:0]    owner_rd;

   logic                        rsp_valid_ff;
   logic [PAGE_NUM_W-1:0]       rsp_page_ff;
   logic                        rsp_status_ff;
   logic                        rsp_last_ff;
   logic [PAGE_NUM_W+IDX_W-1:0] idx_wide;

   poa_ram #(
      .WIDTH(OWNER_W),
      .DEPTH(PAGE_COUNT)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (cmd.claim),
      .wr_addr(idx_ff),
      .wr_data(id_ff),
      .rd_en  (cmd.rd),
      .rd_addr(idx_ff),
      .rd_data(owner_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_cmd;
         id_ff   <= req_owner_id;
         want_ff <= req_page_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         free_cnt_ff <= CNT_W'(PAGE_COUNT);
         idx_ff      <= '0;
         claimed_ff  <= '0;
      end else begin
         if (cmd.latch) begin
            idx_ff     <= '0;
            claimed_ff <= '0;
         end else begin
            if (cmd.step) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (cmd.claim) begin
               claimed_ff <= claimed_ff + 1'b1;
            end
         end
         if (cmd.claim) begin
            used_ff[idx_ff] <= 1'b1;
            free_cnt_ff     <= free_cnt_ff - 1'b1;
         end else if (cmd.release_page) begin
            used_ff[idx_ff] <= 1'b0;
            free_cnt_ff     <= free_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      stat.is_reclaim  = (cmd_ff == CMD_RECLAIM);
      stat.alloc_ok    = (want_ff != '0)
                         && (want_ff <= COUNT_W'(MAX_RESULTS))
                         && (CMP_W'(want_ff) <= CMP_W'(free_cnt_ff));
      stat.page_free   = !used_ff[idx_ff];
      stat.owner_match = used_ff[idx_ff] && (owner_rd == id_ff);
      stat.idx_at_end  = (idx_ff == IDX_W'(PAGE_COUNT - 1));
      stat.last_claim  = ((claimed_ff + 1'b1) == want_ff);
      stat.slot_free   = !rsp_valid_ff || !rsp_stall;
   end

   // page index keeps only its low bits on the result
   assign idx_wide = {{PAGE_NUM_W{1'b0}}, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.emit_kind)
            EMIT_PAGE: begin
               rsp_page_ff   <= idx_wide[PAGE_NUM_W-1:0];
               rsp_status_ff <= 1'b0;
               rsp_last_ff   <= stat.last_claim;
            end
            EMIT_FAIL: begin
               rsp_page_ff   <= '0;
               rsp_status_ff <= 1'b1;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_page_ff   <= '0;
               rsp_status_ff <= 1'b0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_number = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   a_free_count_tracks_used: assert property (@(posedge clock) disable iff (reset)
      ($countones(used_ff) + int'(free_cnt_ff)) == PAGE_COUNT)
      else $error("free count disagrees with used bits");

   a_claim_free_page: assert property (@(posedge clock) disable iff (reset)
      cmd.claim |-> !used_ff[idx_ff])
      else $error("claim of a page already in use");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result beat overwrites a pending one");

   a_release_only_owned: assert property (@(posedge clock) disable iff (reset)
      cmd.release_page |-> (used_ff[idx_ff] && $past(cmd.rd)))
      else $error("release without a fresh owner read");

endmodule

`default_nettype wire

/* rtl/core/page_ownership_allocator.sv */
// Allocate: accept, a check state, then a first-fit scan that skips used pages and claims and
// emits each free page until the last claim; a full result slot holds the scan at a free page.
// Reclaim: each page is read from the owner RAM, then compared and released on a match; the
// acknowledgement is emitted from the response state after the last page. Failure beats
// also come from the response state; one item at a time; output stalls hold the result.
// Reset clears the used bits and sets the free count at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module page_ownership_allocator #(
   parameter int PAGE_COUNT = poa_pkg::PAGE_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cmd,
   input  wire logic [poa_pkg::OWNER_W-1:0]        req_owner_id,
   input  wire logic [poa_pkg::COUNT_W-1:0]        req_page_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [poa_pkg::PAGE_NUM_W-1:0]     rsp_page_number,
   output logic                                    rsp_status,
   output logic                                    rsp_last
);
   import poa_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   poa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   poa_datapath #(
      .PAGE_COUNT(PAGE_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_cmd),
      .req_owner_id   (req_owner_id),
      .req_page_count (req_page_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_page_number(rsp_page_number),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

/* test/page_ownership_allocator_checker.sv */
// Scoreboard for the page ownership allocator: predicts each page grant and checks every beat.
`timescale 1ns / 1ps

module page_ownership_allocator_checker #(
   parameter int PAGES = poa_pkg::PAGE_COUNT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic                           req_cmd,
   input  wire logic [poa_pkg::OWNER_W-1:0]    req_owner_id,
   input  wire logic [poa_pkg::COUNT_W-1:0]    req_page_count,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [poa_pkg::PAGE_NUM_W-1:0] rsp_page_number,
   input  wire logic                           rsp_status,
   input  wire logic                           rsp_last,
   output int                                  errors,
   output int                                  pending
);

   import poa_pkg::*;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [PAGE_NUM_W-1:0] page_number;
      logic                  status;
      logic                  last;
   } grant_beat_type;

   grant_beat_type        grant_queue[$];
   logic                  page_taken [PAGES];
   logic [OWNER_W-1:0]    page_holder[PAGES];

   task automatic predict_grants(input logic cmd, input logic [OWNER_W-1:0] id,
                                 input logic [COUNT_W-1:0] want);
      int             i;
      int             free_pages;
      int             k;
      grant_beat_type beat;
      free_pages = 0;
      k = 0;
      if (cmd == CMD_RECLAIM) begin
         for (i = 0; i < PAGES; i++) begin
            if (page_taken[i] && page_holder[i] == id) begin
               page_taken[i]  = 1'b0;
               page_holder[i] = '0;
            end
         end
         beat.page_number = '0;
         beat.status      = STATUS_OK;
         beat.last        = 1'b1;
         grant_queue.push_back(beat);
      end else begin
         for (i = 0; i < PAGES; i++)
            if (!page_taken[i])
               free_pages++;
         if (want == 0 || want > MAX_RESULTS || want > free_pages) begin
            // leave the table untouched on a refused request
            beat.page_number = '0;
            beat.status      = STATUS_FAIL;
            beat.last        = 1'b1;
            grant_queue.push_back(beat);
         end else begin
            for (i = 0; i < PAGES && k < want; i++) begin
               if (!page_taken[i]) begin
                  page_taken[i]    = 1'b1;
                  page_holder[i]   = id;
                  beat.page_number = i[PAGE_NUM_W-1:0];
                  beat.status      = STATUS_OK;
                  beat.last        = (k + 1 == want);
                  grant_queue.push_back(beat);
                  k++;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      grant_beat_type exp_beat;
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            page_taken[i]  = 1'b0;
            page_holder[i] = '0;
         end
         grant_queue.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual page %0d status %0d last %0d",
                        $time, rsp_page_number, rsp_status, rsp_last);
               errors = errors + 1;
            end else begin
               exp_beat = grant_queue.pop_front();
               if (rsp_page_number !== exp_beat.page_number) begin
                  $display("%0t: page_number mismatch, expected %0d, actual %0d",
                           $time, exp_beat.page_number, rsp_page_number);
                  errors = errors + 1;
               end
               if (rsp_status !== exp_beat.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, exp_beat.status, rsp_status);
                  errors = errors + 1;
               end
               if (rsp_last !== exp_beat.last) begin
                  $display("%0t: last mismatch, expected %0d, actual %0d",
                           $time, exp_beat.last, rsp_last);
                  errors = errors + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_grants(req_cmd, req_owner_id, req_page_count);
      end
      pending <= grant_queue.size();
   end

endmodule

/* test/page_ownership_allocator_tb.sv */
// Top of the page ownership allocator testbench: clock, reset, request and stall stimulus.
`timescale 1ns / 1ps

module page_ownership_allocator_tb;

   import poa_pkg::*;

   localparam logic CMD_ALLOC = 1'b0;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_cmd        = CMD_ALLOC;
   logic [OWNER_W-1:0]    req_owner_id   = '0;
   logic [COUNT_W-1:0]    req_page_count = '0;
   logic                  rsp_stall      = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [PAGE_NUM_W-1:0] rsp_page_number;
   logic                  rsp_status;
   logic                  rsp_last;
   int                    errors;
   int                    pending;
   int                    items_sent     = 0;
   int                    rx_cycle       = 0;
   logic [OWNER_W-1:0]    owner_pool[8];

   always #5 clock = ~clock;

   page_ownership_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_owner_id    (req_owner_id),
      .req_page_count  (req_page_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_page_number (rsp_page_number),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   page_ownership_allocator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_owner_id    (req_owner_id),
      .req_page_count  (req_page_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_page_number (rsp_page_number),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .errors          (errors),
      .pending         (pending)
   );

   // receiver: long hold-off to back up the block, then a clean stretch, else random stalls
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_cycle >= 1500 && rx_cycle < 1900) begin
         rsp_stall <= 1'b1;
      end else if (rx_cycle >= 4000 && rx_cycle < 5500) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   task automatic send_request(input logic cmd, input logic [OWNER_W-1:0] id,
                               input logic [COUNT_W-1:0] count);
      req_cmd        <= cmd;
      req_owner_id   <= id;
      req_page_count <= count;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      // no gaps between beats in the middle stretch
      if (!(items_sent >= 150 && items_sent < 210) && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      int          pick;
      int          slot;
      logic [5:0]  count;
      for (int i = 0; i < 8; i++)
         owner_pool[i] = OWNER_W'($urandom_range(0, 255));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: first fit, refusals, full table, gaps, whole-table grants
      send_request(CMD_ALLOC,   8'h00, 6'd1);
      send_request(CMD_ALLOC,   8'hFF, 6'd3);
      send_request(CMD_ALLOC,   8'h12, 6'd0);
      send_request(CMD_ALLOC,   8'h12, 6'd33);
      send_request(CMD_ALLOC,   8'h12, 6'd63);
      send_request(CMD_ALLOC,   8'h34, 6'd32);
      send_request(CMD_ALLOC,   8'hAA, 6'd28);
      send_request(CMD_ALLOC,   8'h01, 6'd1);
      send_request(CMD_RECLAIM, 8'hFF, 6'd0);
      send_request(CMD_RECLAIM, 8'h55, 6'd63);
      send_request(CMD_ALLOC,   8'h55, 6'd2);
      send_request(CMD_RECLAIM, 8'h00, 6'd1);
      send_request(CMD_ALLOC,   8'h56, 6'd2);
      send_request(CMD_RECLAIM, 8'hAA, 6'd0);
      send_request(CMD_RECLAIM, 8'h55, 6'd0);
      send_request(CMD_RECLAIM, 8'h56, 6'd0);
      send_request(CMD_ALLOC,   8'h80, 6'd32);
      send_request(CMD_ALLOC,   8'h81, 6'd1);
      send_request(CMD_RECLAIM, 8'h80, 6'd0);
      send_request(CMD_ALLOC,   8'h7F, 6'd31);
      send_request(CMD_ALLOC,   8'h01, 6'd1);
      send_request(CMD_RECLAIM, 8'h7F, 6'd0);
      send_request(CMD_RECLAIM, 8'h01, 6'd0);

      // random: mostly pool owners allocating and reclaiming, some noise
      repeat (247) begin
         pick = $urandom_range(0, 99);
         slot = $urandom_range(0, 7);
         if (pick < 55) begin
            count = COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 32)
                                                          : $urandom_range(1, 6));
            send_request(CMD_ALLOC, owner_pool[slot], count);
         end else if (pick < 85) begin
            send_request(CMD_RECLAIM, owner_pool[slot], COUNT_W'($urandom_range(0, 63)));
         end else begin
            send_request(1'($urandom_range(0, 1)), OWNER_W'($urandom_range(0, 255)),
                         COUNT_W'($urandom_range(0, 63)));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
